/* design/gha_pkg.sv */
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared sizes, codes and the command and status types between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int SLOTS     = 256;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int HANDLE_W  = 32;
	localparam int GEN_W     = 8;
	localparam int POS_W     = 24;
	localparam int POS_CMP_W = POS_W + 1;

	localparam logic [HANDLE_W-1:0] NO_HANDLE = '1;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_LOOKUP = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_COMMIT = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	typedef struct packed {
		logic [GEN_W-1:0]  gen;
		logic [SLOT_W-1:0] slot;
	} stack_entry_t;

endpackage

/* design/gha_ctrl.sv */
// ----------------------------------------------------------------------------
// Generational handle allocator controller
// Two-state sequencer: capture a word and read the tables, then commit the
// update and the result once the output register is free.
// ----------------------------------------------------------------------------
module gha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output gha_pkg::cmd_t    cmd,
	input  gha_pkg::dp_sts_t sts
);

	gha_pkg::state_t state_q;
	gha_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gha_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gha_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = gha_pkg::S_COMMIT;
				end
			end
			gha_pkg::S_COMMIT: begin
				if (sts.out_free) begin
					state_d = gha_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gha_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			gha_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			gha_pkg::S_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* design/gha_datapath.sv */
// ----------------------------------------------------------------------------
// Generational handle allocator datapath
// Generation table, free stack, live flags, counters and the output register.
// ----------------------------------------------------------------------------
module gha_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gha_pkg::cmd_t                    cmd,
	output gha_pkg::dp_sts_t                 sts,
	input  logic [1:0]                       opcode,
	input  logic [gha_pkg::HANDLE_W-1:0]     handle_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gha_pkg::HANDLE_W-1:0]     handle_out,
	output logic [1:0]                       status
);

	logic [gha_pkg::GEN_W-1:0]   gen_mem [gha_pkg::SLOTS];
	gha_pkg::stack_entry_t       stk_mem [gha_pkg::SLOTS];

	logic [1:0]                  op_q;
	logic [gha_pkg::HANDLE_W-1:0] handle_q;
	logic [gha_pkg::GEN_W-1:0]   gen_rd_q;
	gha_pkg::stack_entry_t       stk_rd_q;
	logic [gha_pkg::CNT_W-1:0]   free_depth_q;
	logic [gha_pkg::CNT_W-1:0]   slots_used_q;
	logic [gha_pkg::SLOTS-1:0]   slot_live_q;
	logic                        out_valid_q;
	logic [gha_pkg::HANDLE_W-1:0] handle_out_q;
	logic [1:0]                  status_q;

	logic [gha_pkg::CNT_W-1:0]   stk_top;
	logic [gha_pkg::SLOT_W-1:0]  q_slot;
	logic [gha_pkg::GEN_W-1:0]   q_gen;
	logic                        in_range;
	logic                        current;
	logic [gha_pkg::GEN_W-1:0]   pop_gen;

	logic [gha_pkg::HANDLE_W-1:0] res_handle;
	gha_pkg::status_t            res_status;
	logic                        gen_we;
	logic [gha_pkg::SLOT_W-1:0]  tbl_addr;
	logic [gha_pkg::GEN_W-1:0]   gen_wdata;
	logic                        stk_we;
	logic                        live_set;
	logic                        live_clr;
	logic                        depth_inc;
	logic                        depth_dec;
	logic                        used_inc;

	assign stk_top  = free_depth_q - gha_pkg::CNT_W'(1);
	assign q_slot   = handle_q[gha_pkg::SLOT_W-1:0];
	assign q_gen    = handle_q[gha_pkg::HANDLE_W-1:gha_pkg::POS_W];
	assign in_range = {1'b0, handle_q[gha_pkg::POS_W-1:0]} <
		gha_pkg::POS_CMP_W'(slots_used_q);
	assign current  = in_range && slot_live_q[q_slot] && (gen_rd_q == q_gen);
	assign pop_gen  = stk_rd_q.gen + gha_pkg::GEN_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			handle_q <= handle_in;
			gen_rd_q <= gen_mem[handle_in[gha_pkg::SLOT_W-1:0]];
			stk_rd_q <= stk_mem[stk_top[gha_pkg::SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && gen_we) begin
			gen_mem[tbl_addr] <= gen_wdata;
		end
		if (cmd.commit && stk_we) begin
			stk_mem[free_depth_q[gha_pkg::SLOT_W-1:0]] <= '{gen: q_gen, slot: q_slot};
		end
	end

	always_comb begin
		res_handle = handle_q;
		res_status = gha_pkg::ST_MISS;
		gen_we     = 1'b0;
		tbl_addr   = q_slot;
		gen_wdata  = pop_gen;
		stk_we     = 1'b0;
		live_set   = 1'b0;
		live_clr   = 1'b0;
		depth_inc  = 1'b0;
		depth_dec  = 1'b0;
		used_inc   = 1'b0;
		unique case (gha_pkg::opcode_t'(op_q))
			gha_pkg::OP_ALLOC: begin
				priority if (free_depth_q != '0) begin
					tbl_addr   = stk_rd_q.slot;
					gen_wdata  = pop_gen;
					gen_we     = 1'b1;
					live_set   = 1'b1;
					depth_dec  = 1'b1;
					res_handle = {pop_gen, gha_pkg::POS_W'(stk_rd_q.slot)};
					res_status = gha_pkg::ST_OK;
				end else if (slots_used_q != gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
					tbl_addr   = slots_used_q[gha_pkg::SLOT_W-1:0];
					gen_wdata  = '0;
					gen_we     = 1'b1;
					live_set   = 1'b1;
					used_inc   = 1'b1;
					res_handle = {gha_pkg::GEN_W'(0), gha_pkg::POS_W'(slots_used_q)};
					res_status = gha_pkg::ST_OK;
				end else begin
					res_handle = gha_pkg::NO_HANDLE;
					res_status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::OP_FREE: begin
				if (current && (free_depth_q != gha_pkg::CNT_W'(gha_pkg::SLOTS))) begin
					stk_we     = 1'b1;
					live_clr   = 1'b1;
					depth_inc  = 1'b1;
					res_status = gha_pkg::ST_OK;
				end
			end
			gha_pkg::OP_LOOKUP: begin
				if (current) begin
					res_status = gha_pkg::ST_OK;
				end
			end
			default: begin
				res_status = gha_pkg::ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_live_q  <= '0;
			free_depth_q <= '0;
			slots_used_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (live_set) begin
					slot_live_q[tbl_addr] <= 1'b1;
				end
				if (live_clr) begin
					slot_live_q[tbl_addr] <= 1'b0;
				end
				if (depth_inc) begin
					free_depth_q <= free_depth_q + gha_pkg::CNT_W'(1);
				end
				if (depth_dec) begin
					free_depth_q <= free_depth_q - gha_pkg::CNT_W'(1);
				end
				if (used_inc) begin
					slots_used_q <= slots_used_q + gha_pkg::CNT_W'(1);
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			handle_out_q <= res_handle;
			status_q     <= res_status;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign handle_out   = handle_out_q;
	assign status       = status_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_depth_q <= gha_pkg::CNT_W'(gha_pkg::SLOTS))
		else $error("free stack depth beyond table size");

	a_depth_used: assert property (@(posedge clk) disable iff (!arst_n)
		free_depth_q <= slots_used_q)
		else $error("more freed handles than slots handed out");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit overwrote a pending result word");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result word not presented after commit");

endmodule

/* design/generational_handle_allocator.sv */
// ----------------------------------------------------------------------------
// Generational handle allocator
// An accepted input word and its table reads are registered first; the result
// word is registered at the read-modify-write commit, and a new input word is
// taken only after that commit; a stalled output holds the commit state.
// Reset clears the live flags, the free stack depth and the used-slot count;
// the generation table and free stack are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [gha_pkg::HANDLE_W-1:0] handle_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gha_pkg::HANDLE_W-1:0] handle_out,
	output logic [1:0]                   status
);

	gha_pkg::cmd_t    cmd;
	gha_pkg::dp_sts_t sts;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gha_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.handle_out (handle_out),
		.status     (status)
	);

endmodule
